// File: hw/rtl/q_table_argmax_cache_top_defines.svh
// assertion macros for the q-table argmax cache block
// the asserting file provides clk and rst in scope; no other dependencies
`ifndef Q_TABLE_ARGMAX_CACHE_TOP_DEFINES_SVH
`define Q_TABLE_ARGMAX_CACHE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QTAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QTAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/q_tac_pkg.sv
// shared types and constants of the q-table argmax cache block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package q_tac_pkg;

  // configuration port
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int STATES_REG_W = 11;
  localparam int ACTIONS_REG_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_STATES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_EN = 2'd2;

  localparam logic [STATES_REG_W-1:0] STATES_RESET = 11'd1024;
  localparam logic [ACTIONS_REG_W-1:0] ACTIONS_RESET = 5'd16;

  // item modes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INV_STATE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INV_ALL = 3'd4;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_DISPATCH = 8'b0000_0100,
    ST_RDWAIT   = 8'b0000_1000,
    ST_CHECK    = 8'b0001_0000,
    ST_SCAN     = 8'b0010_0000,
    ST_FILL     = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/q_tac_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module q_tac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/q_table_argmax_cache_top.sv
// q-table with per-state row maximum and argmax cache
// uses q_tac_pkg, q_tac_ram and q_table_argmax_cache_top_defines.svh
//
// Input channel (in_valid/in_ready) carries one command beat: mode, state_index,
// action_index, write_value. Write, read and query beats each produce one result
// beat on the output channel (out_valid/out_ready); invalidate beats produce none.
// One command is worked on at a time; in_ready is high only between commands.
// A write passes dispatch and done; a read dispatch, rdwait and done; a query
// hit dispatch, check and done. A query miss reads entry zero in check, scans
// the rest of the row in scan, the entry ram giving one row entry per cycle to
// the compare, and writes the cache word in fill when the cache is enabled;
// invalidate all clears one cache word per cycle.
// After reset the block sweeps the entry ram to zero and clears the cache,
// with in_ready low; configuration writes are taken during the sweep.
// The result sits in an output register; while the receiver stalls, a finished
// result waits in the block and no new command is taken.
// Configuration: cfg_we, cfg_index, cfg_data, to be written only while idle by the user; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

`include "q_table_argmax_cache_top_defines.svh"

module q_table_argmax_cache_top #(
  parameter int MAX_STATES = 1024,
  parameter int MAX_ACTIONS = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,

  input  wire logic                                cfg_we,
  input  wire logic [q_tac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [q_tac_pkg::CFG_DATA_W-1:0]    cfg_data,

  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [q_tac_pkg::MODE_W-1:0]        mode,
  input  wire logic [$clog2(MAX_STATES)-1:0]       state_index,
  input  wire logic [$clog2(MAX_ACTIONS)-1:0]      action_index,
  input  wire logic signed [VALUE_BITS-1:0]        write_value,

  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [VALUE_BITS-1:0]             read_value,
  output logic        [$clog2(MAX_ACTIONS)-1:0]    top_action,
  output logic                                     cache_hit,
  output logic                                     out_of_range
);

  localparam int SBITS = $clog2(MAX_STATES);
  localparam int ABITS = $clog2(MAX_ACTIONS);
  localparam int NBITS = ABITS + 1;
  localparam int EBITS = SBITS + ABITS;
  localparam int EDEPTH = MAX_STATES * (2 ** ABITS);
  localparam int CWIDTH = 1 + ABITS + VALUE_BITS;

  q_tac_pkg::state_t state;

  // configuration registers
  logic [q_tac_pkg::STATES_REG_W-1:0]  states_reg;
  logic [q_tac_pkg::ACTIONS_REG_W-1:0] actions_reg;
  logic                                cache_en;

  // latched command
  logic [q_tac_pkg::MODE_W-1:0] mode_q;
  logic [SBITS-1:0]             st_q;
  logic [ABITS-1:0]             act_q;
  logic [VALUE_BITS-1:0]        wv_q;
  logic                         st_ok_q;
  logic                         act_ok_q;

  // clearing sweep
  logic [EBITS-1:0] clr_cnt;
  logic             clear_entries;
  logic             clr_done;

  // row scan
  logic [ABITS-1:0]      scan_act;
  logic [VALUE_BITS-1:0] best_v;
  logic [ABITS-1:0]      best_a;
  logic [VALUE_BITS-1:0] best_v_next;
  logic [ABITS-1:0]      best_a_next;

  // pending result
  logic [VALUE_BITS-1:0] res_value;
  logic [ABITS-1:0]      res_best;
  logic                  res_hit;
  logic                  res_oor;

  logic [NBITS-1:0] eff_act;
  logic [ABITS-1:0] last_act;
  logic             st_ok;
  logic             act_ok;

  // memory ports
  logic                  ent_we;
  logic [EBITS-1:0]      ent_waddr;
  logic [VALUE_BITS-1:0] ent_wdata;
  logic [EBITS-1:0]      ent_raddr;
  logic [VALUE_BITS-1:0] ent_rdata;
  logic                  cch_we;
  logic [SBITS-1:0]      cch_waddr;
  logic [CWIDTH-1:0]     cch_wdata;
  logic [SBITS-1:0]      cch_raddr;
  logic [CWIDTH-1:0]     cch_rdata;
  logic                  cch_valid;

  assign in_ready = (state == q_tac_pkg::ST_IDLE);
  assign cch_valid = cch_rdata[CWIDTH-1];

  // zero actions act as one, oversize saturates
  always_comb begin
    if (actions_reg == '0) begin
      eff_act = NBITS'(1);
    end else if (32'(actions_reg) > 32'(MAX_ACTIONS)) begin
      eff_act = NBITS'(MAX_ACTIONS);
    end else begin
      eff_act = NBITS'(actions_reg);
    end
  end

  assign last_act = ABITS'(eff_act - NBITS'(1));
  assign st_ok = (32'(state_index) < 32'(states_reg)) && (32'(state_index) < 32'(MAX_STATES));
  assign act_ok = ({1'b0, action_index} < eff_act);

  assign clr_done = (clr_cnt[EBITS-1:ABITS] == SBITS'(MAX_STATES - 1)) &&
                    (!clear_entries || (&clr_cnt[ABITS-1:0]));

  // signed strict-greater keeps the first maximal index
  always_comb begin
    if ($signed(ent_rdata) > $signed(best_v)) begin
      best_v_next = ent_rdata;
      best_a_next = scan_act;
    end else begin
      best_v_next = best_v;
      best_a_next = best_a;
    end
  end

  // memory addressing
  always_comb begin
    ent_we = 1'b0;
    ent_waddr = {st_q, act_q};
    ent_wdata = wv_q;
    ent_raddr = {st_q, act_q};
    cch_we = 1'b0;
    cch_waddr = st_q;
    cch_wdata = '0;
    cch_raddr = st_q;
    unique case (state)
      q_tac_pkg::ST_CLEAR: begin
        ent_we = clear_entries;
        ent_waddr = clr_cnt;
        ent_wdata = '0;
        cch_we = 1'b1;
        cch_waddr = clr_cnt[EBITS-1:ABITS];
      end
      q_tac_pkg::ST_DISPATCH: begin
        case (mode_q)
          q_tac_pkg::MODE_WRITE: begin
            ent_we = st_ok_q && act_ok_q;
            cch_we = st_ok_q && act_ok_q;
          end
          q_tac_pkg::MODE_QUERY: begin
            ent_raddr = {st_q, ABITS'(0)};
          end
          q_tac_pkg::MODE_INV_STATE: begin
            cch_we = st_ok_q;
          end
          default: begin
          end
        endcase
      end
      q_tac_pkg::ST_CHECK: begin
        ent_raddr = {st_q, ABITS'(1)};
      end
      q_tac_pkg::ST_SCAN: begin
        ent_raddr = {st_q, ABITS'(scan_act + ABITS'(1))};
      end
      q_tac_pkg::ST_FILL: begin
        cch_we = 1'b1;
        cch_wdata = {1'b1, best_a, best_v};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= q_tac_pkg::ST_CLEAR;
      clr_cnt <= '0;
      clear_entries <= 1'b1;
      out_valid <= 1'b0;
      states_reg <= q_tac_pkg::STATES_RESET;
      actions_reg <= q_tac_pkg::ACTIONS_RESET;
      cache_en <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          q_tac_pkg::CFG_STATES: states_reg <= cfg_data;
          q_tac_pkg::CFG_ACTIONS: actions_reg <= cfg_data[q_tac_pkg::ACTIONS_REG_W-1:0];
          q_tac_pkg::CFG_CACHE_EN: cache_en <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // in the done state the output register is reloaded instead
      if (out_valid && out_ready && (state != q_tac_pkg::ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        q_tac_pkg::ST_CLEAR: begin
          if (clr_done) begin
            clr_cnt <= '0;
            state <= q_tac_pkg::ST_IDLE;
          end else if (clear_entries) begin
            clr_cnt <= clr_cnt + EBITS'(1);
          end else begin
            clr_cnt <= clr_cnt + EBITS'(2 ** ABITS);
          end
        end
        q_tac_pkg::ST_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            st_q <= state_index;
            act_q <= action_index;
            wv_q <= write_value;
            st_ok_q <= st_ok;
            act_ok_q <= act_ok;
            state <= q_tac_pkg::ST_DISPATCH;
          end
        end
        q_tac_pkg::ST_DISPATCH: begin
          res_value <= '0;
          res_best <= '0;
          res_hit <= 1'b0;
          case (mode_q)
            q_tac_pkg::MODE_WRITE: begin
              res_oor <= !(st_ok_q && act_ok_q);
              state <= q_tac_pkg::ST_DONE;
            end
            q_tac_pkg::MODE_READ: begin
              res_oor <= !(st_ok_q && act_ok_q);
              if (st_ok_q && act_ok_q) begin
                state <= q_tac_pkg::ST_RDWAIT;
              end else begin
                state <= q_tac_pkg::ST_DONE;
              end
            end
            q_tac_pkg::MODE_QUERY: begin
              res_oor <= !st_ok_q;
              if (st_ok_q) begin
                state <= q_tac_pkg::ST_CHECK;
              end else begin
                state <= q_tac_pkg::ST_DONE;
              end
            end
            q_tac_pkg::MODE_INV_ALL: begin
              clear_entries <= 1'b0;
              clr_cnt <= '0;
              state <= q_tac_pkg::ST_CLEAR;
            end
            default: begin
              state <= q_tac_pkg::ST_IDLE;
            end
          endcase
        end
        q_tac_pkg::ST_RDWAIT: begin
          res_value <= ent_rdata;
          state <= q_tac_pkg::ST_DONE;
        end
        q_tac_pkg::ST_CHECK: begin
          if (cache_en && cch_valid) begin
            res_value <= cch_rdata[VALUE_BITS-1:0];
            res_best <= cch_rdata[VALUE_BITS +: ABITS];
            res_hit <= 1'b1;
            state <= q_tac_pkg::ST_DONE;
          end else begin
            // entry zero is the starting best
            best_v <= ent_rdata;
            best_a <= '0;
            res_value <= ent_rdata;
            res_best <= '0;
            scan_act <= ABITS'(1);
            if (last_act != '0) begin
              state <= q_tac_pkg::ST_SCAN;
            end else if (cache_en) begin
              state <= q_tac_pkg::ST_FILL;
            end else begin
              state <= q_tac_pkg::ST_DONE;
            end
          end
        end
        q_tac_pkg::ST_SCAN: begin
          best_v <= best_v_next;
          best_a <= best_a_next;
          res_value <= best_v_next;
          res_best <= best_a_next;
          if (scan_act == last_act) begin
            state <= cache_en ? q_tac_pkg::ST_FILL : q_tac_pkg::ST_DONE;
          end else begin
            scan_act <= scan_act + ABITS'(1);
          end
        end
        q_tac_pkg::ST_FILL: begin
          state <= q_tac_pkg::ST_DONE;
        end
        q_tac_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            read_value <= res_value;
            top_action <= res_best;
            cache_hit <= res_hit;
            out_of_range <= res_oor;
            out_valid <= 1'b1;
            state <= q_tac_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= q_tac_pkg::ST_IDLE;
        end
      endcase
    end
  end

  q_tac_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(EDEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // cache word: valid, best action, row maximum
  q_tac_ram #(
    .WIDTH(CWIDTH),
    .DEPTH(MAX_STATES)
  ) u_cache_ram (
    .clk   (clk),
    .we    (cch_we),
    .waddr (cch_waddr),
    .wdata (cch_wdata),
    .raddr (cch_raddr),
    .rdata (cch_rdata)
  );

  `QTAC_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state == q_tac_pkg::ST_DISPATCH, "accepted beat not dispatched")
  `QTAC_ASSERT_NEXT(a_done_holds, state == q_tac_pkg::ST_DONE && out_valid && !out_ready, state == q_tac_pkg::ST_DONE, "result left while output stalled")
  `QTAC_ASSERT_NOW(a_entry_write_src, ent_we, state == q_tac_pkg::ST_CLEAR || (state == q_tac_pkg::ST_DISPATCH && mode_q == q_tac_pkg::MODE_WRITE && st_ok_q && act_ok_q), "unexpected entry ram write")
  `QTAC_ASSERT_NOW(a_scan_bound, state == q_tac_pkg::ST_SCAN, scan_act <= last_act && scan_act != '0, "scan index out of row")
  `QTAC_ASSERT_NOW(a_hit_in_range, out_valid && cache_hit, !out_of_range, "cache hit flagged out of range")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking bench for the q-table argmax cache block
// depends on q_tac_pkg and q_table_argmax_cache_top; predicts every result beat in-line
`timescale 1ns / 1ps

module testbench;

  localparam int N_STATES = 1024;
  localparam int N_ACTIONS = 16;
  localparam int VAL_W = 32;
  // covers invalidate-all (one cache word per cycle) with margin
  localparam int SETTLE_CYCLES = 1200;

  typedef struct packed {
    logic [q_tac_pkg::MODE_W-1:0] mode;
    logic [9:0]                   st;
    logic [3:0]                   act;
    logic signed [VAL_W-1:0]      val;
  } table_cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [3:0]              best;
    logic                    hit;
    logic                    oob;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_we = 1'b0;
  logic [q_tac_pkg::CFG_IDX_W-1:0]  cfg_index = q_tac_pkg::CFG_STATES;
  logic [q_tac_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [q_tac_pkg::MODE_W-1:0] mode = q_tac_pkg::MODE_READ;
  logic [9:0]                   state_index = '0;
  logic [3:0]                   action_index = '0;
  logic signed [VAL_W-1:0]      write_value = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] read_value;
  logic [3:0]              top_action;
  logic                    cache_hit;
  logic                    out_of_range;

  // mirror of the table, the row caches and the registers
  bit signed [VAL_W-1:0] q_vals [N_STATES][N_ACTIONS];
  bit signed [VAL_W-1:0] row_max_cache [N_STATES];
  bit [3:0]              row_best_cache [N_STATES];
  bit                    row_cached [N_STATES];
  logic [10:0]           states_reg = 11'd1024;
  logic [4:0]            actions_reg = 5'd16;
  bit                    cache_on = 1'b1;

  table_cmd_t   cmd_backlog [$];
  table_reply_t awaited_replies [$];
  table_cmd_t   cur_cmd;
  table_reply_t want;
  int unsigned  idle_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  fail_count = 0;
  bit           gaps_on = 1'b0;
  bit           stalls_on = 1'b0;

  q_table_argmax_cache_top #(
    .MAX_STATES(N_STATES),
    .MAX_ACTIONS(N_ACTIONS),
    .VALUE_BITS(VAL_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .state_index(state_index),
    .action_index(action_index),
    .write_value(write_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .top_action(top_action),
    .cache_hit(cache_hit),
    .out_of_range(out_of_range)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void apply_table_op(table_cmd_t c);
    table_reply_t r;
    int unsigned n_st;
    int unsigned n_act;
    bit st_ok;
    bit act_ok;
    bit signed [VAL_W-1:0] top;
    bit [3:0] top_at;
    n_st = (states_reg > N_STATES) ? N_STATES : states_reg;
    n_act = (actions_reg == 0) ? 1 : ((actions_reg > N_ACTIONS) ? N_ACTIONS : actions_reg);
    st_ok = c.st < n_st;
    act_ok = c.act < n_act;
    r = '0;
    case (c.mode)
      q_tac_pkg::MODE_WRITE: begin
        if (st_ok && act_ok) begin
          q_vals[c.st][c.act] = c.val;
          row_cached[c.st] = 1'b0;
        end else begin
          r.oob = 1'b1;
        end
        awaited_replies.push_back(r);
      end
      q_tac_pkg::MODE_READ: begin
        if (st_ok && act_ok) r.value = q_vals[c.st][c.act];
        else r.oob = 1'b1;
        awaited_replies.push_back(r);
      end
      q_tac_pkg::MODE_QUERY: begin
        if (!st_ok) begin
          r.oob = 1'b1;
        end else if (cache_on && row_cached[c.st]) begin
          r.value = row_max_cache[c.st];
          r.best = row_best_cache[c.st];
          r.hit = 1'b1;
        end else begin
          // strict signed greater, so the lowest index wins a tie
          top = q_vals[c.st][0];
          top_at = '0;
          for (int a = 1; a < n_act; a++) begin
            if (q_vals[c.st][a] > top) begin
              top = q_vals[c.st][a];
              top_at = a[3:0];
            end
          end
          if (cache_on) begin
            row_max_cache[c.st] = top;
            row_best_cache[c.st] = top_at;
            row_cached[c.st] = 1'b1;
          end
          r.value = top;
          r.best = top_at;
        end
        awaited_replies.push_back(r);
      end
      q_tac_pkg::MODE_INV_STATE: begin
        if (st_ok) row_cached[c.st] = 1'b0;
      end
      q_tac_pkg::MODE_INV_ALL: begin
        foreach (row_cached[i]) row_cached[i] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready) apply_table_op(cur_cmd);
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog.pop_front();
          mode <= cur_cmd.mode;
          state_index <= cur_cmd.st;
          action_index <= cur_cmd.act;
          write_value <= cur_cmd.val;
          in_valid <= 1'b1;
          idle_left = gaps_on ? $urandom_range(0, 5) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string what, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $display("%0t %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          fail_count++;
          $display("%0t unexpected beat: expected none, got value %h best %h hit %b oob %b",
                   $time, read_value, top_action, cache_hit, out_of_range);
        end else begin
          want = awaited_replies.pop_front();
          check_field("read_value", want.value, read_value);
          check_field("top_action", 32'(want.best), 32'(top_action));
          check_field("cache_hit", 32'(want.hit), 32'(cache_hit));
          check_field("out_of_range", 32'(want.oob), 32'(out_of_range));
        end
        stall_left = stalls_on ? $urandom_range(0, 5) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [q_tac_pkg::CFG_IDX_W-1:0] idx,
                           logic [q_tac_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      q_tac_pkg::CFG_STATES:   states_reg = data[10:0];
      q_tac_pkg::CFG_ACTIONS:  actions_reg = data[4:0];
      q_tac_pkg::CFG_CACHE_EN: cache_on = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(int unsigned s, int unsigned a, bit c);
    write_reg(q_tac_pkg::CFG_STATES, q_tac_pkg::CFG_DATA_W'(s));
    write_reg(q_tac_pkg::CFG_ACTIONS, q_tac_pkg::CFG_DATA_W'(a));
    write_reg(q_tac_pkg::CFG_CACHE_EN, q_tac_pkg::CFG_DATA_W'(c));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || awaited_replies.size() != 0)
      @(negedge clk);
  endtask

  // invalidates leave no result, so give them time before touching registers
  task automatic reconfigure(int unsigned s, int unsigned a, bit c);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    load_config(s, a, c);
  endtask

  task automatic push_cmd(logic [q_tac_pkg::MODE_W-1:0] m, int unsigned s, int unsigned a,
                          logic [VAL_W-1:0] v);
    table_cmd_t c;
    c.mode = m;
    c.st = 10'(s);
    c.act = 4'(a);
    c.val = v;
    cmd_backlog.push_back(c);
  endtask

  task automatic push_random(int unsigned n);
    int unsigned done_n;
    int unsigned r;
    int unsigned st_lim;
    int unsigned hot_top;
    table_cmd_t c;
    done_n = 0;
    while (done_n < n) begin
      r = $urandom_range(0, 99);
      if (r < 30) c.mode = q_tac_pkg::MODE_WRITE;
      else if (r < 50) c.mode = q_tac_pkg::MODE_READ;
      else if (r < 85) c.mode = q_tac_pkg::MODE_QUERY;
      else if (r < 92) c.mode = q_tac_pkg::MODE_INV_STATE;
      else if (r < 94) c.mode = q_tac_pkg::MODE_INV_ALL;
      else c.mode = q_tac_pkg::MODE_INV_ALL + 3'($urandom_range(1, 3));
      // mostly a few hot rows so that caches fill and get hit
      st_lim = (states_reg > 1023) ? 1023 : states_reg;
      hot_top = (st_lim < 7) ? st_lim : 7;
      r = $urandom_range(0, 99);
      if (r < 70) c.st = 10'($urandom_range(0, hot_top));
      else if (r < 85) c.st = 10'($urandom_range(0, st_lim));
      else c.st = 10'($urandom_range(0, 1023));
      c.act = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0: c.val = 32'h7FFF_FFFF;
        1: c.val = 32'h8000_0000;
        2, 3, 4: c.val = (32'($urandom_range(0, 3)) - 32'd2) << 16;
        default: c.val = $urandom;
      endcase
      cmd_backlog.push_back(c);
      if (c.mode <= q_tac_pkg::MODE_INV_ALL) done_n++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // registers are taken during the clearing sweep
    load_config(1024, 16, 1'b1);
    gaps_on = 1'b1;
    stalls_on = 1'b1;

    // extremes, hit and miss, ties, invalidation
    push_cmd(q_tac_pkg::MODE_WRITE, 0, 0, 32'h7FFF_FFFF);
    push_cmd(q_tac_pkg::MODE_WRITE, 1023, 15, 32'h8000_0000);
    push_cmd(q_tac_pkg::MODE_READ, 0, 0, '0);
    push_cmd(q_tac_pkg::MODE_READ, 1023, 15, '0);
    push_cmd(q_tac_pkg::MODE_QUERY, 0, 0, '0);
    push_cmd(q_tac_pkg::MODE_QUERY, 0, 0, '0);
    push_cmd(q_tac_pkg::MODE_QUERY, 1023, 0, '0);
    push_cmd(q_tac_pkg::MODE_WRITE, 7, 3, 32'h0005_0000);
    push_cmd(q_tac_pkg::MODE_WRITE, 7, 9, 32'h0005_0000);
    push_cmd(q_tac_pkg::MODE_QUERY, 7, 0, '0);
    push_cmd(q_tac_pkg::MODE_INV_STATE, 7, 0, '0);
    push_cmd(q_tac_pkg::MODE_QUERY, 7, 0, '0);
    push_cmd(q_tac_pkg::MODE_WRITE, 0, 0, 32'hFFFF_0000);
    push_cmd(q_tac_pkg::MODE_QUERY, 0, 0, '0);
    push_cmd(q_tac_pkg::MODE_INV_ALL, 0, 0, '0);
    push_cmd(q_tac_pkg::MODE_QUERY, 1023, 0, '0);
    push_cmd(q_tac_pkg::MODE_INV_ALL + 3'd3, 512, 10, 32'h1234_5678);

    push_random(110);
    // sender holds off until every result is back
    wait_drain();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    push_random(110);

    reconfigure(37, 5, 1'b1);
    gaps_on = 1'b1;
    push_cmd(q_tac_pkg::MODE_WRITE, 37, 0, 32'h0001_0000);
    push_cmd(q_tac_pkg::MODE_WRITE, 3, 5, 32'h0002_0000);
    push_cmd(q_tac_pkg::MODE_READ, 40, 2, '0);
    push_cmd(q_tac_pkg::MODE_QUERY, 1023, 0, '0);
    push_cmd(q_tac_pkg::MODE_INV_STATE, 500, 0, '0);
    push_random(140);

    // no valid states; zero actions acts as one
    reconfigure(0, 0, 1'b0);
    gaps_on = 1'b0;
    stalls_on = 1'b1;
    push_cmd(q_tac_pkg::MODE_QUERY, 0, 0, '0);
    push_cmd(q_tac_pkg::MODE_READ, 0, 0, '0);
    push_random(30);

    // oversized registers saturate
    reconfigure(2047, 31, 1'b1);
    gaps_on = 1'b1;
    push_random(120);

    reconfigure(1, 1, 1'b1);
    push_random(50);

    reconfigure(1024, 16, 1'b0);
    push_random(110);

    reconfigure(300, 12, 1'b1);
    push_random(40);

    // widening rows leaves earlier cache entries in place
    reconfigure(300, 16, 1'b1);
    push_random(40);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: q_table_argmax_cache_top.f
+incdir+hw/rtl
hw/rtl/q_tac_pkg.sv
hw/rtl/q_tac_ram.sv
hw/rtl/q_table_argmax_cache_top.sv
tb/testbench.sv
